[rtl/incremental_pi_antiwindup_top_macros.svh]
// Assertion macros for the incremental PI controller.
`ifndef INCREMENTAL_PI_ANTIWINDUP_TOP_MACROS_SVH
`define INCREMENTAL_PI_ANTIWINDUP_TOP_MACROS_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define IPIAW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("controller assertion failed");

// Next-cycle implication, checked on i_clk outside reset.
`define IPIAW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("controller assertion failed");

`endif

[rtl/ipiaw_pkg.sv]
// Types, register codes and saturation helpers for the incremental PI controller.
`timescale 1ns / 1ps

package ipiaw_pkg;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    typedef enum logic [ADDR_W-1:0] {
        REG_TARGET = 3'd0,
        REG_KP     = 3'd1,
        REG_KI     = 3'd2,
        REG_UPPER  = 3'd3,
        REG_LOWER  = 3'd4,
        REG_INIT   = 3'd5
    } t_reg_idx;

    localparam logic [DATA_W-1:0] RST_TARGET = 32'd524288;
    localparam logic [DATA_W-1:0] RST_KP     = 32'd3276800;
    localparam logic [DATA_W-1:0] RST_KI     = 32'd32768;
    localparam logic [DATA_W-1:0] RST_UPPER  = 32'd65536;
    localparam logic [DATA_W-1:0] RST_LOWER  = 32'd6554;
    localparam logic [DATA_W-1:0] RST_INIT   = 32'd65536;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [DATA_W-1:0] kp;
        logic [DATA_W-1:0] ki;
    } t_gains;

    typedef struct packed {
        logic signed [DATA_W-1:0] upper;
        logic signed [DATA_W-1:0] lower;
        logic signed [DATA_W-1:0] init;
    } t_limits;

    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1]) begin
            r = v[DATA_W] ? S32_MIN : S32_MAX;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat34(input logic signed [DATA_W+1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = S32_MAX;
        end else if (v < -34'sh0_8000_0000) begin
            r = S32_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat65(input logic signed [2*DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 65'sh0_0000_0000_7FFF_FFFF) begin
            r = S32_MAX;
        end else if (v < -65'sh0_0000_0000_8000_0000) begin
            r = S32_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/ipiaw_err.sv]
// Error stage: saturated error and error change against the previous item.
`timescale 1ns / 1ps

module ipiaw_err #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_load,
    input  logic signed [ipiaw_pkg::DATA_W-1:0]    i_meas,
    input  logic signed [ipiaw_pkg::DATA_W-1:0]    i_target,
    output logic signed [ipiaw_pkg::DATA_W-1:0]    o_err,
    output logic signed [ipiaw_pkg::DATA_W-1:0]    o_delta
);

    localparam logic signed [ipiaw_pkg::DATA_W-1:0] PREV_RST =
        ipiaw_pkg::DATA_W'(1) << FRAC_BITS;

    logic signed [ipiaw_pkg::DATA_W-1:0] r_prev_err;
    logic signed [ipiaw_pkg::DATA_W-1:0] r_err;
    logic signed [ipiaw_pkg::DATA_W-1:0] r_delta;
    logic signed [ipiaw_pkg::DATA_W-1:0] n_err;
    logic signed [ipiaw_pkg::DATA_W-1:0] n_delta;

    always_comb begin
        n_err   = ipiaw_pkg::sat33({i_target[ipiaw_pkg::DATA_W-1], i_target}
                                   - {i_meas[ipiaw_pkg::DATA_W-1], i_meas});
        n_delta = ipiaw_pkg::sat33({n_err[ipiaw_pkg::DATA_W-1], n_err}
                                   - {r_prev_err[ipiaw_pkg::DATA_W-1], r_prev_err});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= PREV_RST;
        end else if (i_load) begin
            r_prev_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_err   <= n_err;
            r_delta <= n_delta;
        end
    end

    assign o_err   = r_err;
    assign o_delta = r_delta;

endmodule

[rtl/ipiaw_mul.sv]
// Product stage: gain times error change and gain times error.
`timescale 1ns / 1ps

module ipiaw_mul (
    input  logic                                   i_clk,
    input  logic                                   i_load,
    input  ipiaw_pkg::t_gains                      i_gains,
    input  logic signed [ipiaw_pkg::DATA_W-1:0]    i_err,
    input  logic signed [ipiaw_pkg::DATA_W-1:0]    i_delta,
    output logic signed [2*ipiaw_pkg::DATA_W:0]    o_pprod,
    output logic signed [2*ipiaw_pkg::DATA_W:0]    o_iprod,
    output logic signed [ipiaw_pkg::DATA_W-1:0]    o_err
);

    logic signed [2*ipiaw_pkg::DATA_W:0] r_pprod;
    logic signed [2*ipiaw_pkg::DATA_W:0] r_iprod;
    logic signed [ipiaw_pkg::DATA_W-1:0] r_err;
    logic signed [2*ipiaw_pkg::DATA_W:0] n_pprod;
    logic signed [2*ipiaw_pkg::DATA_W:0] n_iprod;

    always_comb begin
        n_pprod = $signed({1'b0, i_gains.kp}) * i_delta;
        n_iprod = $signed({1'b0, i_gains.ki}) * i_err;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pprod <= n_pprod;
            r_iprod <= n_iprod;
            r_err   <= i_err;
        end
    end

    assign o_pprod = r_pprod;
    assign o_iprod = r_iprod;
    assign o_err   = r_err;

endmodule

[rtl/ipiaw_acc.sv]
// Accumulator stage: output update, anti-windup, startup reload and clamp.
`timescale 1ns / 1ps

module ipiaw_acc #(
    parameter int FRAC_BITS      = 16,
    parameter int STARTUP_WINDOW = 50
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_load,
    input  ipiaw_pkg::t_limits                     i_limits,
    input  logic signed [2*ipiaw_pkg::DATA_W:0]    i_pprod,
    input  logic signed [2*ipiaw_pkg::DATA_W:0]    i_iprod,
    input  logic signed [ipiaw_pkg::DATA_W-1:0]    i_err,
    output logic signed [ipiaw_pkg::DATA_W-1:0]    o_accum,
    output logic signed [ipiaw_pkg::DATA_W-1:0]    o_err,
    output logic                                   o_int_en,
    output logic                                   o_reload,
    output logic                                   o_reload_next
);

    localparam int CNT_W = $clog2(STARTUP_WINDOW + 1);
    localparam logic [CNT_W-1:0] WIN = CNT_W'(STARTUP_WINDOW);
    localparam logic signed [ipiaw_pkg::DATA_W-1:0] ACC_RST =
        ipiaw_pkg::DATA_W'(1) << FRAC_BITS;

    logic signed [ipiaw_pkg::DATA_W-1:0] r_accum;
    logic signed [ipiaw_pkg::DATA_W-1:0] r_err;
    logic                                r_int_en;
    logic                                r_reload;
    logic [CNT_W-1:0]                    r_cnt;

    logic signed [2*ipiaw_pkg::DATA_W:0] p_sh;
    logic signed [2*ipiaw_pkg::DATA_W:0] i_sh;
    logic signed [ipiaw_pkg::DATA_W-1:0] p_term;
    logic signed [ipiaw_pkg::DATA_W-1:0] i_term;
    logic signed [ipiaw_pkg::DATA_W+1:0] sum;
    logic signed [ipiaw_pkg::DATA_W-1:0] acc;
    logic                                above;
    logic                                below;
    logic                                err_pos;
    logic                                err_neg;
    logic [CNT_W-1:0]                    cnt_inc;
    logic signed [ipiaw_pkg::DATA_W-1:0] n_accum;
    logic                                n_int_en;
    logic                                n_reload;
    logic [CNT_W-1:0]                    n_cnt;

    always_comb begin
        p_sh    = i_pprod >>> FRAC_BITS;
        i_sh    = i_iprod >>> FRAC_BITS;
        p_term  = ipiaw_pkg::sat65(p_sh);
        i_term  = r_int_en ? ipiaw_pkg::sat65(i_sh) : '0;
        sum     = $signed({{2{r_accum[ipiaw_pkg::DATA_W-1]}}, r_accum})
                + $signed({{2{p_term[ipiaw_pkg::DATA_W-1]}}, p_term})
                + $signed({{2{i_term[ipiaw_pkg::DATA_W-1]}}, i_term});
        acc     = ipiaw_pkg::sat34(sum);
        above   = acc > i_limits.upper;
        below   = acc < i_limits.lower;
        err_neg = i_err[ipiaw_pkg::DATA_W-1];
        err_pos = !err_neg && (i_err != '0);
        cnt_inc = (r_cnt < WIN) ? r_cnt + CNT_W'(1) : r_cnt;

        n_int_en = !((above && err_pos) || (below && err_neg));
        n_reload = 1'b0;
        n_cnt    = cnt_inc;
        n_accum  = acc;
        if (above) begin
            if (cnt_inc < WIN) begin
                n_accum  = i_limits.init;
                n_cnt    = WIN;
                n_reload = 1'b1;
            end else begin
                n_accum = i_limits.upper;
            end
        end else if (below) begin
            n_accum = i_limits.lower;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum  <= ACC_RST;
            r_int_en <= 1'b1;
            r_cnt    <= '0;
        end else if (i_load) begin
            r_accum  <= n_accum;
            r_int_en <= n_int_en;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_err    <= i_err;
            r_reload <= n_reload;
        end
    end

    assign o_accum       = r_accum;
    assign o_err         = r_err;
    assign o_int_en      = r_int_en;
    assign o_reload      = r_reload;
    assign o_reload_next = n_reload;

endmodule

[rtl/incremental_pi_antiwindup_top.sv]
// Top level of the incremental PI controller with anti-windup.
`timescale 1ns / 1ps

// One measured sample in, one controller result out. The block takes an item
// every cycle while the result side keeps up. Each accepted item passes
// through the input register, the error stage, the multiplier stage and the
// accumulator/result register in that order. The output recurrence closes
// inside the last stage, so throughput is one item per cycle while the
// result side keeps up; each stage holds when the stage after it is full and
// stalled.
module incremental_pi_antiwindup_top #(
    parameter int FRAC_BITS      = 16,
    parameter int STARTUP_WINDOW = 50
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,   // [31:0] measured_value
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [63:0]                   m_axis_tdata,   // [31:0] control_output,
                                                          // [63:32] error_value
    output logic [1:0]                    m_axis_tuser,   // [0] integration_on,
                                                          // [1] startup_reload
    input  logic                          i_cfg_we,
    input  logic [ipiaw_pkg::ADDR_W-1:0]  i_cfg_addr,
    input  logic [ipiaw_pkg::DATA_W-1:0]  i_cfg_wdata
);

    `include "incremental_pi_antiwindup_top_macros.svh"

    logic signed [ipiaw_pkg::DATA_W-1:0] r_target;
    ipiaw_pkg::t_gains                   r_gains;
    ipiaw_pkg::t_limits                  r_limits;

    logic signed [ipiaw_pkg::DATA_W-1:0] r_meas;
    logic                                r_v1;
    logic                                r_v2;
    logic                                r_v3;
    logic                                r_vo;
    logic                                en1;
    logic                                en2;
    logic                                en3;
    logic                                eno;

    logic signed [ipiaw_pkg::DATA_W-1:0] err2;
    logic signed [ipiaw_pkg::DATA_W-1:0] delta2;
    logic signed [2*ipiaw_pkg::DATA_W:0] pprod3;
    logic signed [2*ipiaw_pkg::DATA_W:0] iprod3;
    logic signed [ipiaw_pkg::DATA_W-1:0] err3;
    logic signed [ipiaw_pkg::DATA_W-1:0] accum;
    logic signed [ipiaw_pkg::DATA_W-1:0] err_o;
    logic                                int_en;
    logic                                reload;
    logic                                reload_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target        <= ipiaw_pkg::RST_TARGET;
            r_gains.kp      <= ipiaw_pkg::RST_KP;
            r_gains.ki      <= ipiaw_pkg::RST_KI;
            r_limits.upper  <= ipiaw_pkg::RST_UPPER;
            r_limits.lower  <= ipiaw_pkg::RST_LOWER;
            r_limits.init   <= ipiaw_pkg::RST_INIT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ipiaw_pkg::REG_TARGET: r_target       <= i_cfg_wdata;
                ipiaw_pkg::REG_KP:     r_gains.kp     <= i_cfg_wdata;
                ipiaw_pkg::REG_KI:     r_gains.ki     <= i_cfg_wdata;
                ipiaw_pkg::REG_UPPER:  r_limits.upper <= i_cfg_wdata;
                ipiaw_pkg::REG_LOWER:  r_limits.lower <= i_cfg_wdata;
                ipiaw_pkg::REG_INIT:   r_limits.init  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        eno = !r_vo || m_axis_tready;
        en3 = !r_v3 || eno;
        en2 = !r_v2 || en3;
        en1 = !r_v1 || en2;
    end

    assign s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en1) r_v1 <= s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (eno) r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && s_axis_tvalid) begin
            r_meas <= s_axis_tdata;
        end
    end

    ipiaw_err #(
        .FRAC_BITS (FRAC_BITS)
    ) u_err (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (en2 && r_v1),
        .i_meas   (r_meas),
        .i_target (r_target),
        .o_err    (err2),
        .o_delta  (delta2)
    );

    ipiaw_mul u_mul (
        .i_clk   (i_clk),
        .i_load  (en3 && r_v2),
        .i_gains (r_gains),
        .i_err   (err2),
        .i_delta (delta2),
        .o_pprod (pprod3),
        .o_iprod (iprod3),
        .o_err   (err3)
    );

    ipiaw_acc #(
        .FRAC_BITS      (FRAC_BITS),
        .STARTUP_WINDOW (STARTUP_WINDOW)
    ) u_acc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (eno && r_v3),
        .i_limits      (r_limits),
        .i_pprod       (pprod3),
        .i_iprod       (iprod3),
        .i_err         (err3),
        .o_accum       (accum),
        .o_err         (err_o),
        .o_int_en      (int_en),
        .o_reload      (reload),
        .o_reload_next (reload_next)
    );

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {err_o, accum};
    assign m_axis_tuser  = {reload, int_en};

    `IPIAW_ASSERT_IMP(a_reload_value, r_vo && reload, accum == r_limits.init)

    `IPIAW_ASSERT_IMP(a_within_limits,
        r_vo && !reload && (r_limits.upper >= r_limits.lower),
        (accum <= r_limits.upper) && (accum >= r_limits.lower))

    `IPIAW_ASSERT_IMP(a_ready_only_on_stall, !s_axis_tready, r_vo && !m_axis_tready)

    `IPIAW_ASSERT_NXT(a_reload_once, eno && r_v3 && reload_next,
        !(eno && r_v3 && reload_next))

endmodule
